[rtl/fcca_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcca_pkg
// Shared types and constants for the cluster chain allocator.
// ----------------------------------------------------------------------------
package fcca_pkg;

  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_ALLOC = 3'd2;
  localparam logic [2:0] OP_FREE  = 3'd3;
  localparam logic [2:0] OP_SECT  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_LIMIT = 2'd3;

  localparam logic [1:0] CFG_COUNT = 2'd0;
  localparam logic [1:0] CFG_START = 2'd1;
  localparam logic [1:0] CFG_SPC   = 2'd2;

  localparam logic [27:0] MIN_CLUSTER = 28'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_WAIT,
    S_RD_DATA,
    S_SCAN_RD,
    S_SCAN_WAIT,
    S_SCAN_CHK,
    S_LINK_PREV,
    S_FREE_RD,
    S_FREE_WAIT,
    S_FREE_CHK,
    S_MUL,
    S_DONE
  } state_t;

endpackage

[rtl/fcca_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcca_ram
// Generic single port RAM with registered read.
// ----------------------------------------------------------------------------
module fcca_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 4098
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/fcca_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcca_mul
// Shift-add multiplier, one bit of the 8-bit factor per cycle.
// ----------------------------------------------------------------------------
module fcca_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] base,
  input  logic [31:0] mcand,
  input  logic [7:0]  mplier,
  output logic        done,
  output logic [31:0] prod
);

  logic [31:0] acc_r, acc_nxt;
  logic [31:0] mc_r, mc_nxt;
  logic [7:0]  mp_r, mp_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      acc_nxt  = base;
      mc_nxt   = mcand;
      mp_nxt   = mplier;
      cnt_nxt  = 4'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mp_r[0]) begin
        acc_nxt = acc_r + mc_r;
      end
      mc_nxt  = {mc_r[30:0], 1'b0};
      mp_nxt  = {1'b0, mp_r[7:1]};
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd7) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
  end

  assign done = busy_r && (cnt_r == 4'd7);
  assign prod = mp_r[0] ? acc_r + mc_r : acc_r;

endmodule

[rtl/fat_cluster_chain_allocator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_cluster_chain_allocator_core
// Cluster link table with read, write, chain allocate, chain free and
// sector address operations.
// ----------------------------------------------------------------------------
// One operation at a time through a single-port link table RAM with a
// registered read. After reset a clearing pass writes every table entry to
// zero, during which no item is accepted. Sector address runs through an
// 8-step shift-add multiplier; allocation scans the table one entry at a
// time with a link step per cluster taken; free walks the chain one entry
// at a time. The result sits in an output register until taken.
module fat_cluster_chain_allocator_core #(
  parameter int MAX_CLUSTERS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [27:0] in_cluster_num,
  input  logic [27:0] in_entry_value,
  input  logic [12:0] in_alloc_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [27:0] out_result_value,
  output logic [31:0] out_sector_addr,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int DEPTH = MAX_CLUSTERS + 2;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [27:0] END_MARK = 28'd268435448;

  logic [12:0] cfg_count_r;
  logic [31:0] cfg_start_r;
  logic [7:0]  cfg_spc_r;

  fcca_pkg::state_t state_r, state_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [27:0] cl_r, cl_nxt;
  logic [27:0] val_r, val_nxt;
  logic [12:0] cnt_r, cnt_nxt;
  logic [28:0] hint_r, hint_nxt;
  logic [27:0] cur_r, cur_nxt;
  logic [27:0] start_r, start_nxt;
  logic        wrap_r, wrap_nxt;
  logic [27:0] prev_r, prev_nxt;
  logic [27:0] first_r, first_nxt;
  logic [28:0] steps_r, steps_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic        ov_r, ov_nxt;
  logic [1:0]  ost_r, ost_nxt;
  logic [27:0] ores_r, ores_nxt;
  logic [31:0] osec_r, osec_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [27:0]   ram_wdata, ram_rdata;

  logic        mul_start, mul_done;
  logic [31:0] mul_prod;

  logic [27:0] last_cl;
  logic [27:0] limit_eff;

  fcca_ram #(.WIDTH(28), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  fcca_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .base(cfg_start_r),
    .mcand({4'd0, cl_r} - 32'd2), .mplier(cfg_spc_r), .done(mul_done), .prod(mul_prod)
  );

  always_comb begin
    if ({15'd0, cfg_count_r} > 28'(MAX_CLUSTERS)) begin
      limit_eff = 28'(MAX_CLUSTERS);
    end else begin
      limit_eff = {15'd0, cfg_count_r};
    end
    last_cl = limit_eff + 28'd1;
  end

  assign in_ready         = (state_r == fcca_pkg::S_IDLE) && !ov_r;
  assign out_valid        = ov_r;
  assign out_status       = ost_r;
  assign out_result_value = ores_r;
  assign out_sector_addr  = osec_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r; cl_nxt = cl_r; val_nxt = val_r; cnt_nxt = cnt_r;
    hint_nxt = hint_r; cur_nxt = cur_r; start_nxt = start_r; wrap_nxt = wrap_r;
    prev_nxt = prev_r; first_nxt = first_r; steps_nxt = steps_r; clr_nxt = clr_r;
    ov_nxt = ov_r; ost_nxt = ost_r; ores_nxt = ores_r; osec_nxt = osec_r;
    ram_we = 1'b0;
    ram_addr = cur_r[AW-1:0];
    ram_wdata = 28'd0;
    mul_start = 1'b0;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      fcca_pkg::S_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = clr_r;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = fcca_pkg::S_IDLE;
        end
        clr_nxt = clr_r + AW'(1);
      end
      fcca_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          op_nxt = in_opcode; cl_nxt = in_cluster_num;
          val_nxt = in_entry_value; cnt_nxt = in_alloc_count;
          ost_nxt = fcca_pkg::ST_OK; ores_nxt = 28'd0; osec_nxt = 32'd0;
          state_nxt = fcca_pkg::S_DONE;
          case (in_opcode)
            fcca_pkg::OP_READ, fcca_pkg::OP_WRITE: begin
              if (in_cluster_num < fcca_pkg::MIN_CLUSTER || in_cluster_num > last_cl) begin
                ost_nxt = fcca_pkg::ST_RANGE;
              end else begin
                cur_nxt = in_cluster_num;
                state_nxt = fcca_pkg::S_RD_WAIT;
              end
            end
            fcca_pkg::OP_ALLOC: begin
              if (in_alloc_count == 13'd0) begin
                ost_nxt = fcca_pkg::ST_FULL;
              end else begin
                start_nxt = (hint_r >= 29'd2) ? hint_r[27:0] : fcca_pkg::MIN_CLUSTER;
                if (hint_r[28]) begin
                  start_nxt = END_MARK;  // any value above last cluster acts the same
                end
                cur_nxt = start_nxt;
                wrap_nxt = 1'b0;
                prev_nxt = 28'd0;
                first_nxt = 28'd0;
                state_nxt = fcca_pkg::S_SCAN_RD;
              end
            end
            fcca_pkg::OP_FREE: begin
              cur_nxt = in_cluster_num;
              steps_nxt = 29'd0;
              state_nxt = fcca_pkg::S_FREE_RD;
            end
            fcca_pkg::OP_SECT: begin
              state_nxt = fcca_pkg::S_MUL;
            end
            default: ;
          endcase
        end
      end
      fcca_pkg::S_RD_WAIT: begin
        if (op_r == fcca_pkg::OP_WRITE) begin
          ram_we = 1'b1;
          ram_wdata = val_r;
          state_nxt = fcca_pkg::S_DONE;
        end else begin
          state_nxt = fcca_pkg::S_RD_DATA;
        end
      end
      fcca_pkg::S_RD_DATA: begin
        ores_nxt = ram_rdata;
        state_nxt = fcca_pkg::S_DONE;
      end
      fcca_pkg::S_SCAN_RD: begin
        // bounds: first pass start..last, second pass 2..start-1
        if ((!wrap_r && cur_r > last_cl) || (wrap_r && (cur_r >= start_r || cur_r > last_cl))) begin
          if (!wrap_r) begin
            wrap_nxt = 1'b1;
            cur_nxt = fcca_pkg::MIN_CLUSTER;
          end else begin
            ost_nxt = fcca_pkg::ST_FULL;
            state_nxt = fcca_pkg::S_DONE;
          end
        end else begin
          state_nxt = fcca_pkg::S_SCAN_WAIT;
        end
      end
      fcca_pkg::S_SCAN_WAIT: begin
        state_nxt = fcca_pkg::S_SCAN_CHK;
      end
      fcca_pkg::S_SCAN_CHK: begin
        if (ram_rdata == 28'd0) begin
          ram_we = 1'b1;
          ram_wdata = END_MARK;
          hint_nxt = {1'b0, cur_r} + 29'd1;
          if (first_r == 28'd0) begin
            first_nxt = cur_r;
          end
          cnt_nxt = cnt_r - 13'd1;
          state_nxt = fcca_pkg::S_LINK_PREV;
        end else begin
          cur_nxt = cur_r + 28'd1;
          state_nxt = fcca_pkg::S_SCAN_RD;
        end
      end
      fcca_pkg::S_LINK_PREV: begin
        if (prev_r != 28'd0) begin
          ram_we = 1'b1;
          ram_addr = prev_r[AW-1:0];
          ram_wdata = cur_r;
        end
        prev_nxt = cur_r;
        if (cnt_r == 13'd0) begin
          ores_nxt = first_r;
          state_nxt = fcca_pkg::S_DONE;
        end else begin
          start_nxt = hint_r[27:0];
          cur_nxt = hint_r[27:0];
          wrap_nxt = 1'b0;
          state_nxt = fcca_pkg::S_SCAN_RD;
        end
      end
      fcca_pkg::S_FREE_RD: begin
        if (cur_r < fcca_pkg::MIN_CLUSTER || cur_r >= END_MARK) begin
          if (cl_r >= fcca_pkg::MIN_CLUSTER && {1'b0, cl_r} < hint_r) begin
            hint_nxt = {1'b0, cl_r};
          end
          state_nxt = fcca_pkg::S_DONE;
        end else if (cur_r > last_cl) begin
          ost_nxt = fcca_pkg::ST_RANGE;
          state_nxt = fcca_pkg::S_DONE;
        end else if (steps_r >= {1'b0, last_cl}) begin
          ost_nxt = fcca_pkg::ST_LIMIT;
          state_nxt = fcca_pkg::S_DONE;
        end else begin
          steps_nxt = steps_r + 29'd1;
          state_nxt = fcca_pkg::S_FREE_WAIT;
        end
      end
      fcca_pkg::S_FREE_WAIT: begin
        state_nxt = fcca_pkg::S_FREE_CHK;
      end
      fcca_pkg::S_FREE_CHK: begin
        ram_we = 1'b1;
        // a terminal link maps to a value that ends the walk next step
        if (ram_rdata >= END_MARK || ram_rdata < fcca_pkg::MIN_CLUSTER) begin
          cur_nxt = 28'd0;
        end else begin
          cur_nxt = ram_rdata;
        end
        state_nxt = fcca_pkg::S_FREE_RD;
      end
      fcca_pkg::S_MUL: begin
        if (mul_done) begin
          osec_nxt = mul_prod;
          state_nxt = fcca_pkg::S_DONE;
        end
      end
      fcca_pkg::S_DONE: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          state_nxt = fcca_pkg::S_IDLE;
        end
      end
      default: state_nxt = fcca_pkg::S_IDLE;
    endcase
    if (state_r == fcca_pkg::S_IDLE && in_valid && in_ready && in_opcode == fcca_pkg::OP_SECT) begin
      mul_start = 1'b0;
    end
    if (state_r == fcca_pkg::S_MUL && steps_r == 29'd0 && !mul_done) begin
      mul_start = 1'b1;
      steps_nxt = 29'd1;
    end
    if (state_r == fcca_pkg::S_IDLE) begin
      steps_nxt = 29'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcca_pkg::S_CLEAR;
      clr_r       <= '0;
      hint_r      <= 29'd2;
      ov_r        <= 1'b0;
      steps_r     <= 29'd0;
      cfg_count_r <= 13'd4096;
      cfg_start_r <= 32'd0;
      cfg_spc_r   <= 8'd8;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      hint_r  <= hint_nxt;
      ov_r    <= ov_nxt;
      steps_r <= steps_nxt;
      if (cfg_we) begin
        case (cfg_index)
          fcca_pkg::CFG_COUNT: cfg_count_r <= cfg_data[12:0];
          fcca_pkg::CFG_START: cfg_start_r <= cfg_data;
          fcca_pkg::CFG_SPC:   cfg_spc_r   <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
    op_r <= op_nxt; cl_r <= cl_nxt; val_r <= val_nxt; cnt_r <= cnt_nxt;
    cur_r <= cur_nxt; start_r <= start_nxt; wrap_r <= wrap_nxt;
    prev_r <= prev_nxt; first_r <= first_nxt;
    ost_r <= ost_nxt; ores_r <= ores_nxt; osec_r <= osec_nxt;
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cluster chain allocator: a queue-fed driver,
// a link table model that predicts each response, and a response checker,
// run over several volume geometries with random handshake stalls.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [27:0] END_MARK   = 28'hFFFFFF8;
  localparam logic [1:0]  CFG_UNUSED = 2'd3;
  localparam int          TBL_LAST   = 4097;
  localparam int          LIMIT      = 50000000;

  typedef struct packed {
    logic [2:0]  op;
    logic [27:0] cl;
    logic [27:0] val;
    logic [12:0] cnt;
  } fat_op_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [27:0] res;
    logic [31:0] sec;
  } fat_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0]  in_opcode = '0;
  logic [27:0] in_cluster_num = '0;
  logic [27:0] in_entry_value = '0;
  logic [12:0] in_alloc_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [27:0] out_result_value;
  logic [31:0] out_sector_addr;
  logic cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  fat_op_t  pending_ops[$];
  fat_rsp_t expected_rsps[$];
  fat_op_t  cur_op;
  int       errors = 0;
  int       cycles = 0;
  int       accepted = 0;
  int       stall_mode = 0;

  // model state
  logic [27:0] links[0:TBL_LAST];
  logic [28:0] hint;
  logic [12:0] vol_clusters;
  logic [31:0] vol_start;
  logic [7:0]  vol_spc;

  fat_cluster_chain_allocator_core i_dut (.*);

  always #5 clk = ~clk;

  function automatic int eff_count();
    return (vol_clusters > 13'd4096) ? 4096 : int'(vol_clusters);
  endfunction

  function automatic bit in_range(logic [27:0] c);
    return c >= fcca_pkg::MIN_CLUSTER && int'(c) <= eff_count() + 1;
  endfunction

  function automatic bit take_free(output logic [27:0] found);
    int first;
    int last;
    first = (hint >= 29'd2) ? int'(hint) : 2;
    last = eff_count() + 1;
    for (int c = first; c <= last; c++) begin
      if (links[c] == '0) begin
        found = 28'(c);
        hint = 29'(c + 1);
        return 1'b1;
      end
    end
    for (int c = 2; c < first && c <= last; c++) begin
      if (links[c] == '0) begin
        found = 28'(c);
        hint = 29'(c + 1);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [1:0] alloc_chain(logic [12:0] cnt, output logic [27:0] head);
    logic [27:0] prev;
    logic [27:0] c;
    prev = '0;
    head = '0;
    if (cnt == '0) return fcca_pkg::ST_FULL;
    for (int i = 0; i < int'(cnt); i++) begin
      if (!take_free(c)) return fcca_pkg::ST_FULL;
      links[c] = END_MARK;
      if (prev != '0) links[prev] = c;
      if (head == '0) head = c;
      prev = c;
    end
    return fcca_pkg::ST_OK;
  endfunction

  function automatic logic [1:0] free_chain(logic [27:0] start);
    logic [27:0] c;
    logic [27:0] nxt;
    int steps;
    c = start;
    steps = 0;
    while (c >= fcca_pkg::MIN_CLUSTER && c < END_MARK) begin
      if (!in_range(c)) return fcca_pkg::ST_RANGE;
      if (steps >= eff_count() + 1) return fcca_pkg::ST_LIMIT;
      steps++;
      nxt = links[c];
      links[c] = '0;
      if (nxt >= END_MARK || nxt < fcca_pkg::MIN_CLUSTER) break;
      c = nxt;
    end
    if (start >= fcca_pkg::MIN_CLUSTER && 29'(start) < hint) hint = 29'(start);
    return fcca_pkg::ST_OK;
  endfunction

  function automatic fat_rsp_t table_op(fat_op_t op);
    fat_rsp_t r;
    logic [27:0] head;
    r = '0;
    case (op.op)
      fcca_pkg::OP_READ: begin
        if (in_range(op.cl)) r.res = links[op.cl];
        else r.st = fcca_pkg::ST_RANGE;
      end
      fcca_pkg::OP_WRITE: begin
        if (in_range(op.cl)) links[op.cl] = op.val;
        else r.st = fcca_pkg::ST_RANGE;
      end
      fcca_pkg::OP_ALLOC: begin
        r.st = alloc_chain(op.cnt, head);
        if (r.st == fcca_pkg::ST_OK) r.res = head;
      end
      fcca_pkg::OP_FREE: r.st = free_chain(op.cl);
      fcca_pkg::OP_SECT: r.sec = vol_start + (32'(op.cl) - 32'd2) * 32'(vol_spc);
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic bit go_now(int idle_pct_mode0, int idle_pct_mode1);
    if (stall_mode == 0) return $urandom_range(99) >= idle_pct_mode0;
    if (stall_mode == 1) return $urandom_range(99) >= idle_pct_mode1;
    return 1'b1;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_rsps.push_back(table_op(cur_op));
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_ops.size() > 0 && go_now(21, 56)) begin
          cur_op = pending_ops.pop_front();
          in_opcode <= cur_op.op;
          in_cluster_num <= cur_op.cl;
          in_entry_value <= cur_op.val;
          in_alloc_count <= cur_op.cnt;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // response checker
  always @(posedge clk) begin
    fat_rsp_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected transfer", 32'(out_status), 32'd0);
        end else begin
          want = expected_rsps.pop_front();
          if (out_status !== want.st) report_mismatch("status", 32'(out_status), 32'(want.st));
          if (out_result_value !== want.res)
            report_mismatch("result_value", 32'(out_result_value), 32'(want.res));
          if (out_sector_addr !== want.sec)
            report_mismatch("sector_addr", out_sector_addr, want.sec);
        end
      end
      out_ready <= go_now(56, 21);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_op(logic [2:0] op, logic [27:0] cl, logic [27:0] val, logic [12:0] cnt);
    fat_op_t o;
    o.op = op;
    o.cl = cl;
    o.val = val;
    o.cnt = cnt;
    pending_ops.push_back(o);
  endtask

  task automatic drain();
    wait (pending_ops.size() == 0 && !in_valid && expected_rsps.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      fcca_pkg::CFG_COUNT: vol_clusters = val[12:0];
      fcca_pkg::CFG_START: vol_start = val;
      fcca_pkg::CFG_SPC:   vol_spc = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [27:0] pick_cluster();
    if ($urandom_range(9) == 0) return 28'($urandom);
    return 28'($urandom_range(eff_count() + 3, 0));
  endfunction

  task automatic push_random();
    int r;
    logic [27:0] v;
    logic [12:0] n;
    r = $urandom_range(99);
    case ($urandom_range(9))
      0, 1, 2, 3: v = '0;
      4, 5, 6:    v = 28'($urandom_range(eff_count() + 1, 2));
      7:          v = END_MARK + 28'($urandom_range(7));
      default:    v = 28'($urandom);
    endcase
    case ($urandom_range(19))
      0:       n = '0;
      1:       n = 13'($urandom);
      default: n = 13'($urandom_range(8, 1));
    endcase
    if (r < 15)      push_op(fcca_pkg::OP_READ, pick_cluster(), 28'($urandom), n);
    else if (r < 35) push_op(fcca_pkg::OP_WRITE, pick_cluster(), v, n);
    else if (r < 60) push_op(fcca_pkg::OP_ALLOC, 28'($urandom), v, n);
    else if (r < 85) push_op(fcca_pkg::OP_FREE, pick_cluster(), v, n);
    else if (r < 93) push_op(fcca_pkg::OP_SECT, 28'($urandom), v, n);
    else push_op(3'($urandom_range(7, 5)), pick_cluster(), v, n);
  endtask

  initial begin
    int geo_count[8];
    int geo_spc[8];
    geo_count = '{8, 0, 1, 37, 200, 4096, 8191, 16};
    geo_spc = '{1, 128, 255, 0, 8, 8, 64, 3};
    for (int i = 0; i <= TBL_LAST; i++) links[i] = '0;
    hint = 29'd2;
    vol_clusters = 13'd4096;
    vol_start = '0;
    vol_spc = 8'd8;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset geometry
    push_op(fcca_pkg::OP_READ, 28'd0, '0, '0);
    push_op(fcca_pkg::OP_READ, 28'd1, '0, '0);
    push_op(fcca_pkg::OP_READ, 28'd4097, '0, '0);
    push_op(fcca_pkg::OP_READ, 28'd4098, '0, '0);
    push_op(fcca_pkg::OP_READ, 28'hFFFFFFF, 28'hFFFFFFF, 13'h1FFF);
    push_op(fcca_pkg::OP_WRITE, 28'd4097, 28'hFFFFFFF, '0);
    push_op(fcca_pkg::OP_READ, 28'd4097, '0, '0);
    push_op(fcca_pkg::OP_WRITE, 28'd1, 28'd5, '0);
    push_op(fcca_pkg::OP_ALLOC, '0, '0, 13'd0);
    push_op(fcca_pkg::OP_ALLOC, '0, '0, 13'd3);
    push_op(fcca_pkg::OP_READ, 28'd2, '0, '0);
    push_op(fcca_pkg::OP_FREE, 28'd2, '0, '0);
    push_op(fcca_pkg::OP_FREE, 28'd0, '0, '0);
    push_op(fcca_pkg::OP_FREE, END_MARK, '0, '0);
    push_op(fcca_pkg::OP_SECT, 28'd0, '0, '0);
    push_op(fcca_pkg::OP_SECT, 28'hFFFFFFF, '0, '0);
    push_op(3'd5, 28'd3, 28'd3, 13'd3);
    push_op(3'd6, '0, '0, '0);
    push_op(3'd7, 28'hFFFFFFF, 28'hFFFFFFF, 13'h1FFF);
    drain();

    // small volume: run out of clusters, then free into an out-of-range link
    cfg_write(fcca_pkg::CFG_COUNT, 32'd8);
    cfg_write(CFG_UNUSED, 32'hFFFFFFFF);
    push_op(fcca_pkg::OP_ALLOC, '0, '0, 13'd10);
    push_op(fcca_pkg::OP_READ, 28'd9, '0, '0);
    push_op(fcca_pkg::OP_FREE, 28'd5, '0, '0);
    push_op(fcca_pkg::OP_WRITE, 28'd3, 28'd100, '0);
    push_op(fcca_pkg::OP_FREE, 28'd3, '0, '0);
    push_op(fcca_pkg::OP_ALLOC, '0, '0, 13'd2);
    drain();

    for (int g = 0; g < 8; g++) begin
      cfg_write(fcca_pkg::CFG_COUNT, 32'(geo_count[g]));
      cfg_write(fcca_pkg::CFG_START, (g == 1) ? 32'hFFFFFFFF : (g == 0) ? 32'd0 : $urandom);
      cfg_write(fcca_pkg::CFG_SPC, 32'(geo_spc[g]));
      for (int k = 0; k < 250; k++) push_random();
      // stall pattern follows overall progress
      while (pending_ops.size() > 0) begin
        @(posedge clk);
        stall_mode = (accepted < 700) ? 0 : (accepted < 1400) ? 1 : 2;
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
rtl/fcca_pkg.sv
rtl/fcca_ram.sv
rtl/fcca_mul.sv
rtl/fat_cluster_chain_allocator_core.sv
verif/tb_top.sv
